@@ rtl/core/mr_pkg.sv @@
// shared types and constants for the miller-rabin round block
package mr_pkg;

   localparam int WORD_BITS_DEFAULT = 64;
   localparam int FIELD_BITS = 64;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [FIELD_BITS-1:0] candidate;
      logic [FIELD_BITS-1:0] witness;
   } req_type;

   typedef struct packed {
      logic verdict;
      logic error;
   } rsp_type;

   // item classes decided by the front part
   typedef enum logic [1:0] {
      CLS_ERROR = 2'd0,
      CLS_QUICK = 2'd1,
      CLS_FULL  = 2'd2
   } cls_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RED_WAIT,
      ST_BASE,
      ST_SPLIT,
      ST_POW_SEL,
      ST_MUL,
      ST_POW_NEXT,
      ST_CHECK,
      ST_SQR,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/mr_front.sv @@
// front part: takes request words, classifies them and queues the work
module mr_front #(
   parameter int WORD_BITS = mr_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mr_pkg::req_type        req_data,
   output logic                   q_valid,
   input  logic                   q_take,
   output mr_pkg::cls_type        q_cls,
   output logic [WORD_BITS-1:0]   q_n,
   output logic [WORD_BITS-1:0]   q_w
);

   localparam int PTR_BITS = $clog2(mr_pkg::QUEUE_DEPTH);

   mr_pkg::cls_type        cls_mem [mr_pkg::QUEUE_DEPTH];
   logic [WORD_BITS-1:0]   n_mem   [mr_pkg::QUEUE_DEPTH];
   logic [WORD_BITS-1:0]   w_mem   [mr_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]      count_ff;
   logic [WORD_BITS-1:0]   n_cut, w_cut;
   mr_pkg::cls_type        cls;
   logic                   push, pop;

   assign n_cut = req_data.candidate[WORD_BITS-1:0];
   assign w_cut = req_data.witness[WORD_BITS-1:0];

   always_comb begin
      if (n_cut < WORD_BITS'(3)) begin
         cls = mr_pkg::CLS_ERROR;
      end else if (!n_cut[0] || n_cut == WORD_BITS'(3)) begin
         cls = mr_pkg::CLS_QUICK;
      end else begin
         cls = mr_pkg::CLS_FULL;
      end
   end

   assign req_stall = (count_ff == (PTR_BITS+1)'(mr_pkg::QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (count_ff != '0);
   assign pop = q_valid && q_take;
   assign q_cls = cls_mem[rd_ptr_ff];
   assign q_n = n_mem[rd_ptr_ff];
   assign q_w = w_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         cls_mem[wr_ptr_ff] <= cls;
         n_mem[wr_ptr_ff] <= n_cut;
         w_mem[wr_ptr_ff] <= w_cut;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
      end
   end

endmodule

@@ rtl/core/mr_mulmod.sv @@
// shift-and-add modular multiplier, one multiplier bit per cycle
module mr_mulmod #(
   parameter int WORD_BITS = mr_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   input  logic [WORD_BITS-1:0] m,
   output logic                 done,
   output logic [WORD_BITS-1:0] product
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] acc_ff, a_ff, b_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 busy_ff, done_ff;
   logic [WORD_BITS:0]   dbl, dbl_sub, add, add_sub;
   logic [WORD_BITS-1:0] acc_dbl, acc_in;

   // a+b mod m with a,b < m via one wide add and compare
   always_comb begin
      dbl = {1'b0, acc_ff} + {1'b0, acc_ff};
      dbl_sub = dbl - {1'b0, m};
      acc_dbl = (dbl >= {1'b0, m}) ? dbl_sub[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
      add = {1'b0, acc_dbl} + {1'b0, a_ff};
      add_sub = add - {1'b0, m};
      if (b_ff[WORD_BITS-1]) begin
         acc_in = (add >= {1'b0, m}) ? add_sub[WORD_BITS-1:0] : add[WORD_BITS-1:0];
      end else begin
         acc_in = acc_dbl;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff <= a;
         b_ff <= b;
         cnt_ff <= CNT_BITS'(WORD_BITS-1);
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff <= b_ff << 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == '0;
         if (start) busy_ff <= 1'b1;
         else if (cnt_ff == '0) busy_ff <= 1'b0;
      end
   end

endmodule

@@ rtl/core/mr_back.sv @@
// back part: carries out the round on queued work and holds the result word
module mr_back #(
   parameter int WORD_BITS = mr_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_take,
   input  mr_pkg::cls_type        q_cls,
   input  logic [WORD_BITS-1:0]   q_n,
   input  logic [WORD_BITS-1:0]   q_w,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mr_pkg::rsp_type        rsp_data
);

   localparam int PW_BITS = $clog2(WORD_BITS);

   mr_pkg::state_type    state_ff, state_in;
   logic [WORD_BITS-1:0] n_ff, w_ff, e_ff, res_ff, nm1;
   logic [PW_BITS-1:0]   pw_ff;
   logic                 sel_sq_ff;
   logic                 first_ff;
   logic                 rsp_valid_ff;
   mr_pkg::rsp_type      rsp_ff;
   logic                 mul_start, mul_done;
   logic [WORD_BITS-1:0] mul_a, mul_b, mul_p;
   logic                 pass_now, finish;
   logic                 composite;

   assign nm1 = n_ff - 1'b1;

   mr_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .m(n_ff), .done(mul_done), .product(mul_p)
   );

   // 1 only counts before any squaring; n-1 counts at every check
   assign pass_now = (first_ff && res_ff == WORD_BITS'(1)) || res_ff == nm1;
   assign finish = pass_now || pw_ff == PW_BITS'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mr_pkg::ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               state_in = (q_cls == mr_pkg::CLS_FULL) ? mr_pkg::ST_REDUCE : mr_pkg::ST_DONE;
            end
         end
         mr_pkg::ST_REDUCE: begin
            state_in = (w_ff < n_ff) ? mr_pkg::ST_BASE : mr_pkg::ST_RED_WAIT;
         end
         mr_pkg::ST_RED_WAIT: if (mul_done) state_in = mr_pkg::ST_BASE;
         mr_pkg::ST_BASE:     state_in = mr_pkg::ST_SPLIT;
         mr_pkg::ST_SPLIT:    if (e_ff[0]) state_in = mr_pkg::ST_POW_SEL;
         mr_pkg::ST_POW_SEL:  state_in = (e_ff == '0) ? mr_pkg::ST_CHECK : mr_pkg::ST_MUL;
         mr_pkg::ST_MUL:      if (mul_done) state_in = mr_pkg::ST_POW_NEXT;
         mr_pkg::ST_POW_NEXT: state_in = mr_pkg::ST_POW_SEL;
         mr_pkg::ST_CHECK:    state_in = finish ? mr_pkg::ST_DONE : mr_pkg::ST_SQR;
         mr_pkg::ST_SQR:      if (mul_done) state_in = mr_pkg::ST_CHECK;
         mr_pkg::ST_DONE:     state_in = mr_pkg::ST_IDLE;
         default:             state_in = mr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_take = 1'b0;
      mul_start = 1'b0;
      mul_a = res_ff;
      mul_b = res_ff;
      case (state_ff)
         mr_pkg::ST_IDLE:     q_take = q_valid && !rsp_valid_ff;
         mr_pkg::ST_REDUCE: begin
            // witness mod n as 1 * witness mod n
            mul_start = (w_ff >= n_ff);
            mul_a = WORD_BITS'(1);
            mul_b = w_ff;
         end
         mr_pkg::ST_POW_SEL: begin
            mul_start = (e_ff != '0);
            mul_a = e_ff[0] ? res_ff : w_ff;
            mul_b = w_ff;
         end
         mr_pkg::ST_CHECK: begin
            mul_start = !finish;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // composite unless 1 seen at the start or n-1 at any step
   assign composite = !pass_now;

   always_ff @(posedge clock) begin
      case (state_ff)
         mr_pkg::ST_IDLE: begin
            if (q_take) begin
               n_ff <= q_n;
               w_ff <= q_w;
               rsp_ff.error <= (q_cls == mr_pkg::CLS_ERROR);
               rsp_ff.verdict <= 1'b0;
               sel_sq_ff <= 1'b0;
            end
         end
         mr_pkg::ST_RED_WAIT: begin
            if (mul_done) w_ff <= mul_p;
         end
         mr_pkg::ST_BASE: begin
            if (w_ff < WORD_BITS'(2)) w_ff <= w_ff + WORD_BITS'(2);
            e_ff <= nm1;
            pw_ff <= '0;
            res_ff <= WORD_BITS'(1);
            first_ff <= 1'b1;
         end
         mr_pkg::ST_SPLIT: begin
            if (!e_ff[0]) begin
               e_ff <= e_ff >> 1;
               pw_ff <= pw_ff + 1'b1;
            end
         end
         mr_pkg::ST_POW_SEL: begin
            // odd exponent bit: multiply result; else square base
            sel_sq_ff <= !e_ff[0];
         end
         mr_pkg::ST_POW_NEXT: begin
            if (sel_sq_ff) begin
               w_ff <= mul_p;
               e_ff <= e_ff >> 1;
            end else begin
               res_ff <= mul_p;
               e_ff <= {e_ff[WORD_BITS-1:1], 1'b0};
            end
         end
         mr_pkg::ST_CHECK: begin
            if (finish) rsp_ff.verdict <= composite;
         end
         mr_pkg::ST_SQR: begin
            if (mul_done) begin
               res_ff <= mul_p;
               pw_ff <= pw_ff - 1'b1;
               first_ff <= 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (reset) begin
         state_ff <= mr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == mr_pkg::ST_DONE) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ rtl/core/miller_rabin_round.sv @@
// top level of the miller-rabin round block
// work: error, even or three words skip the round; otherwise one squaring per bit of the odd
//   part but the top one plus a multiply per set bit, then up to power-1 squarings, plus one
//   multiply to reduce a witness at or above the candidate
// throughput: one word at a time in the back part, set by the shared bit-serial multiplier;
//   a two-entry queue takes new words in; reset: synchronous, clears queue, sequencer and flag
module miller_rabin_round #(
   parameter int WORD_BITS = mr_pkg::WORD_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output mr_pkg::rsp_type rsp_data
);

   // queue between front and back
   logic                 q_valid, q_take;
   mr_pkg::cls_type      q_cls;
   logic [WORD_BITS-1:0] q_n, q_w;

   // front: word masking and classification into error, quick or full
   mr_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_valid(q_valid), .q_take(q_take), .q_cls(q_cls), .q_n(q_n), .q_w(q_w)
   );

   // back: witness reduction, odd part split, power and squaring chain
   mr_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_cls(q_cls), .q_n(q_n), .q_w(q_w),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

@@ rtl/core/mr_checker.sv @@
// port-level checks for the miller-rabin round block, bound to the top level
module mr_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input mr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed under stall");

   a_err_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> !rsp_data.verdict)
      else $error("error word with composite verdict");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word after reset");

   a_known: assert property (@(posedge clock) disable iff (reset)
      !reset |-> !$isunknown({req_valid, req_stall, rsp_valid}))
      else $error("handshake signal unknown");

endmodule

bind miller_rabin_round mr_checker u_mr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

@@ bench/tb_miller_rabin_round.sv @@
// self-checking bench for the miller-rabin round block: directed table, then random words
module tb_miller_rabin_round;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  WORD_BITS    = 64;
   localparam int  RANDOM_WORDS = 80;
   localparam int  HOLD_CYCLES  = 40000;  // long receiver hold-off, several rounds' worth
   localparam int  DRAIN_CYCLES = 200;
   localparam int  CYCLE_LIMIT  = 8000000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PRIME_TOP = 64'hFFFF_FFFF_FFFF_FFC5;  // largest 64-bit prime

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   mr_pkg::req_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   mr_pkg::rsp_type rsp_data;

   miller_rabin_round #(.WORD_BITS(WORD_BITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // one directed row; the verdict is typed in only where it is obvious
   typedef struct {
      logic [63:0]     candidate;
      logic [63:0]     witness;
      bit              typed;
      mr_pkg::rsp_type verdict_word;
   } row_type;

   mr_pkg::rsp_type verdict_queue[$];
   int unsigned     fail_count;
   int unsigned     cycle_count;
   bit              stimulus_done;
   bit              random_phase;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // exact modular product through a 128-bit intermediate
   function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] m);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return 64'(wide % {64'd0, m});
   endfunction

   function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] e,
                                             logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      while (e != 0) begin
         if (e[0]) begin
            acc = mod_product(acc, base, m);
         end
         base = mod_product(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // outcome of one round for a request word
   function automatic mr_pkg::rsp_type round_outcome(mr_pkg::req_type word);
      mr_pkg::rsp_type outcome;
      logic [63:0]     n;
      logic [63:0]     w;
      logic [63:0]     n_less;
      logic [63:0]     odd_part;
      logic [63:0]     x;
      int              power;
      bit              composite;
      n = word.candidate;
      w = word.witness;
      outcome = '0;
      if (n < 3) begin
         outcome.error = 1'b1;
         return outcome;
      end
      if (!n[0] || n == 3) begin
         return outcome;
      end
      if (w >= n) begin
         w = w % n;
      end
      if (w < 2) begin
         w = w + 2;
      end
      n_less = n - 1;
      odd_part = n_less;
      power = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         power++;
      end
      x = mod_power(w, odd_part, n);
      composite = 1'b1;
      if (x == 1) begin
         composite = 1'b0;
      end else begin
         for (int i = 0; i < power; i++) begin
            if (x == n_less) begin
               composite = 1'b0;
               break;
            end
            x = mod_product(x, x, n);
         end
      end
      outcome.verdict = composite;
      return outcome;
   endfunction

   // offer one word and hold it until taken; valid stays high into the next word
   task automatic offer_word(mr_pkg::req_type word, bit typed, mr_pkg::rsp_type typed_word);
      req_data  <= word;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      verdict_queue.push_back(typed ? typed_word : round_outcome(word));
   endtask

   // random gap after a burst of words
   task automatic burst_gap(inout int left);
      int gap;
      left--;
      if (left <= 0) begin
         left = $urandom_range(1, 8);
         gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // random word; small candidates get both small and full-width witnesses
   function automatic mr_pkg::req_type random_word();
      mr_pkg::req_type word;
      logic [63:0]     primes[4];
      int              pick;
      primes[0] = PRIME_TOP;
      primes[1] = 64'h1FFF_FFFF_FFFF_FFFF;  // mersenne prime 2^61-1
      primes[2] = 64'd1000000007;
      primes[3] = 64'h7FFF_FFFF;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         word.candidate = {1'b1, 31'($urandom), $urandom};
         word.candidate[0] = 1'b1;
         word.witness = {$urandom, $urandom};
      end else if (pick < 60) begin
         word.candidate = 64'($urandom_range(5, 65535)) | 64'd1;
         word.witness = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom}
                        : 64'($urandom_range(0, 32'(word.candidate - 1)));
      end else if (pick < 80) begin
         word.candidate = primes[$urandom_range(0, 3)];
         word.witness = {$urandom, $urandom} % word.candidate;
      end else if (pick < 90) begin
         word.candidate = {1'b1, 31'($urandom), $urandom};
         word.candidate[0] = ($urandom_range(0, 1) == 1);
         word.witness = {$urandom, $urandom};
      end else begin
         // error, even and three cases with any witness
         word.candidate = ($urandom_range(0, 1) == 1) ? 64'($urandom_range(0, 3))
                          : ({$urandom, $urandom} & ~64'd1);
         word.witness = {$urandom, $urandom};
      end
      return word;
   endfunction

   // stimulus: directed table, then random words
   initial begin
      row_type         rows[$];
      mr_pkg::req_type word;
      mr_pkg::rsp_type ok_word;
      mr_pkg::rsp_type err_word;
      int              left;
      ok_word  = '0;
      err_word = '0;
      err_word.error = 1'b1;
      stimulus_done = 1'b0;
      random_phase  = 1'b0;
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // candidates below three give the error flag
      rows.push_back('{64'd0, 64'd0, 1'b1, err_word});
      rows.push_back('{64'd1, ALL_ONES, 1'b1, err_word});
      rows.push_back('{64'd2, 64'd7, 1'b1, err_word});
      // even candidate or three: inconclusive at once
      rows.push_back('{64'd3, ALL_ONES, 1'b1, ok_word});
      rows.push_back('{64'd4, 64'd3, 1'b1, ok_word});
      rows.push_back('{ALL_ONES - 1, ALL_ONES, 1'b1, ok_word});
      // witness below two is lifted to two or three
      rows.push_back('{64'd5, 64'd0, 1'b0, ok_word});
      rows.push_back('{64'd5, 64'd1, 1'b0, ok_word});
      rows.push_back('{64'd9, 64'd0, 1'b0, ok_word});
      // witness equal to candidate minus one never shows composite
      rows.push_back('{64'd5, 64'd4, 1'b1, ok_word});
      rows.push_back('{PRIME_TOP, PRIME_TOP - 1, 1'b1, ok_word});
      // witness at or above the candidate is reduced first
      rows.push_back('{PRIME_TOP, PRIME_TOP, 1'b0, ok_word});
      rows.push_back('{PRIME_TOP, ALL_ONES, 1'b0, ok_word});
      rows.push_back('{ALL_ONES, ALL_ONES, 1'b0, ok_word});
      rows.push_back('{ALL_ONES, 64'h5555_5555_5555_5555, 1'b0, ok_word});
      rows.push_back('{64'd5, ALL_ONES, 1'b0, ok_word});
      // small composites, a carmichael number and primes
      rows.push_back('{64'd9, 64'd2, 1'b0, ok_word});
      rows.push_back('{64'd561, 64'd2, 1'b0, ok_word});
      rows.push_back('{64'd7, 64'd6, 1'b1, ok_word});
      rows.push_back('{64'h1FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ok_word});
      rows.push_back('{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ok_word});

      left = $urandom_range(1, 8);
      foreach (rows[i]) begin
         word.candidate = rows[i].candidate;
         word.witness   = rows[i].witness;
         offer_word(word, rows[i].typed, rows[i].verdict_word);
         burst_gap(left);
      end

      random_phase = 1'b1;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         offer_word(random_word(), 1'b0, ok_word);
         burst_gap(left);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // receiver stall pattern: free, light and heavy stretches, plus one long hold-off
   initial begin
      int mode;
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (random_phase && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            // sender keeps offering, so the queue fills and req_stall rises
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (cycle_count % 64 == 0) begin
            mode = $urandom_range(0, 2);
         end
         case (mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   // result checker: every accepted word against the oldest expectation
   always @(posedge clock) begin
      mr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            $display("%0t: unexpected result word %b", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_data.verdict !== want.verdict) begin
               $display("%0t: verdict expected %b actual %b", $realtime,
                        want.verdict, rsp_data.verdict);
               fail_count++;
            end
            if (rsp_data.error !== want.error) begin
               $display("%0t: error expected %b actual %b", $realtime,
                        want.error, rsp_data.error);
               fail_count++;
            end
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // end of run: drain, let the block settle, then report
   initial begin
      fail_count  = 0;
      cycle_count = 0;
      wait (stimulus_done);
      while (verdict_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && verdict_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
